// ----- rtl/haversine_distance_macros.svh -----
// assertion macros for the haversine distance checker
// no dependencies
`ifndef HAVERSINE_DISTANCE_MACROS_SVH
`define HAVERSINE_DISTANCE_MACROS_SVH
// implication checked on every clock edge outside reset
`define HD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define HD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/hav_pkg.sv -----
// shared constants, types and functions for the haversine distance block
// no dependencies
`default_nettype none
package hav_pkg;
  localparam int CordicSteps = 30;
  localparam int RadiusW = 23;
  localparam int DistW = 25;
  localparam int Latency = 100;
  localparam logic [RadiusW-1:0] RadiusReset = 23'd6378137;
  localparam logic signed [33:0] OneQ30 = 34'sd1073741824;
  localparam logic signed [33:0] GainInv = 34'sd652032874;
  localparam logic [31:0] PiQ30 = 32'd3373259426;
  localparam logic [2:0] AddrRadius = 3'd0;

  // cordic arctangent table in binary angle units
  function automatic logic signed [33:0] atan_tab(input int i);
    logic signed [33:0] v;
    case (i)
      0: v = 34'sd536870912;  1: v = 34'sd316933406;  2: v = 34'sd167458907;
      3: v = 34'sd85004756;   4: v = 34'sd42667331;   5: v = 34'sd21354465;
      6: v = 34'sd10680862;   7: v = 34'sd5340245;    8: v = 34'sd2670163;
      9: v = 34'sd1335087;    10: v = 34'sd667544;    11: v = 34'sd333772;
      12: v = 34'sd166886;    13: v = 34'sd83443;     14: v = 34'sd41721;
      15: v = 34'sd20861;     16: v = 34'sd10430;     17: v = 34'sd5215;
      18: v = 34'sd2608;      19: v = 34'sd1304;      20: v = 34'sd652;
      21: v = 34'sd326;       22: v = 34'sd163;       23: v = 34'sd81;
      24: v = 34'sd41;        25: v = 34'sd20;        26: v = 34'sd10;
      27: v = 34'sd5;         28: v = 34'sd3;         29: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // state of one cordic lane
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cordic_t;
endpackage
`default_nettype wire

// ----- rtl/hav_cos.sv -----
// pipelined rotation cordic cosine, one iteration per stage, q1.30 out
// depends on hav_pkg
`default_nettype none
module hav_cos import hav_pkg::*; (
  input  wire logic clk,
  input  wire logic [31:0] angle,
  output logic signed [33:0] cosv
);
  cordic_t st [0:CordicSteps];
  logic flip [0:CordicSteps];
  logic signed [33:0] z0;

  // fold angle into +/- quarter turn
  always_comb begin
    z0 = 34'(signed'(angle));
    flip[0] = 1'b0;
    if (z0 > OneQ30) begin
      z0 = z0 - 34'sd2147483648;
      flip[0] = 1'b1;
    end else if (z0 < -OneQ30) begin
      z0 = z0 + 34'sd2147483648;
      flip[0] = 1'b1;
    end
    st[0] = '{x: GainInv, y: 34'sd0, z: z0};
  end

  // one registered iteration per stage
  for (genvar i = 0; i < CordicSteps; i++) begin : g_it
    always_ff @(posedge clk) begin
      flip[i+1] <= flip[i];
      if (st[i].z >= 0) begin
        st[i+1].x <= st[i].x - (st[i].y >>> i);
        st[i+1].y <= st[i].y + (st[i].x >>> i);
        st[i+1].z <= st[i].z - atan_tab(i);
      end else begin
        st[i+1].x <= st[i].x + (st[i].y >>> i);
        st[i+1].y <= st[i].y - (st[i].x >>> i);
        st[i+1].z <= st[i].z + atan_tab(i);
      end
    end
  end

  // clamp and apply sign, registered
  logic signed [33:0] xc;
  always_comb begin
    xc = st[CordicSteps].x;
    if (xc > OneQ30) xc = OneQ30;
    if (xc < 0) xc = 34'sd0;
  end
  always_ff @(posedge clk) begin
    cosv <= flip[CordicSteps] ? -xc : xc;
  end
endmodule
`default_nettype wire

// ----- rtl/hav_sqrt.sv -----
// pipelined restoring square root of a 61-bit value, one result bit per stage
// depends on hav_pkg
`default_nettype none
module hav_sqrt import hav_pkg::*; (
  input  wire logic clk,
  input  wire logic [60:0] radicand,
  output logic [30:0] root
);
  logic [60:0] rem [0:31];
  logic [30:0] res [0:31];
  assign rem[0] = radicand;
  assign res[0] = '0;

  // each stage decides one root bit, msb first
  for (genvar k = 0; k < 31; k++) begin : g_bit
    localparam int B = 30 - k;
    logic [63:0] trial;
    assign trial = ({33'd0, res[k]} << (B + 1)) + (64'd1 << (2 * B));
    always_ff @(posedge clk) begin
      if ({3'b000, rem[k]} >= trial) begin
        rem[k+1] <= 61'({3'b000, rem[k]} - trial);
        res[k+1] <= res[k] | (31'd1 << B);
      end else begin
        rem[k+1] <= rem[k];
        res[k+1] <= res[k];
      end
    end
  end
  assign root = res[31];
endmodule
`default_nettype wire

// ----- rtl/haversine_distance.sv -----
// Haversine great-circle distance, fully pipelined: one coordinate pair may
// start in every cycle (busy is always low) and its result appears on
// distance_m/coord_error with done high after passing through the chain of a
// 31-stage cosine cordic, a 3-stage product and haversine step, a 31-stage
// square root, a 30-stage arcsine cordic and a 5-stage scale to meters.
// The receiver cannot stall; results are never held.
// The radius register must only be written while no item is in flight.
// depends on hav_pkg, hav_cos, hav_sqrt
`default_nettype none
module haversine_distance import hav_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic [31:0] from_lat,
  input  wire logic [31:0] from_lon,
  input  wire logic [31:0] to_lat,
  input  wire logic [31:0] to_lon,
  output logic done,
  output logic [DistW-1:0] distance_m,
  output logic coord_error,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic [RadiusW-1:0] radius;
  assign pready = 1'b1;
  assign busy = 1'b0;

  // radius register
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RadiusReset;
    end else if (psel && penable && pwrite && paddr == AddrRadius) begin
      radius <= pwdata[RadiusW-1:0];
    end
  end
  assign prdata = (paddr == AddrRadius) ? {9'd0, radius} : 32'd0;

  // valid and error flags travel alongside the data
  logic [Latency-1:0] vpipe;
  logic [Latency-1:0] epipe;
  logic err_in;
  assign err_in = ($signed(from_lat) < -32'sd1073741824) ||
                  ($signed(from_lat) > 32'sd1073741824) ||
                  ($signed(to_lat) < -32'sd1073741824) ||
                  ($signed(to_lat) > 32'sd1073741824);
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[Latency-2:0], start};
    end
    epipe <= {epipe[Latency-2:0], err_in};
  end

  // four cosines
  logic signed [33:0] c1, c2, cdlat, cdlon;
  hav_cos u_c1 (.clk, .angle(from_lat), .cosv(c1));
  hav_cos u_c2 (.clk, .angle(to_lat), .cosv(c2));
  hav_cos u_cla (.clk, .angle(to_lat - from_lat), .cosv(cdlat));
  hav_cos u_clo (.clk, .angle(to_lon - from_lon), .cosv(cdlon));

  // product of latitude cosines, then times one minus cosine of longitude difference
  logic [30:0] c1p, c2p;
  logic [30:0] p;
  logic [31:0] omdlon;
  logic signed [33:0] cdlat_d, cdlat_d2;
  always_comb begin
    c1p = (c1 < 0) ? 31'd0 : c1[30:0];
    c2p = (c2 < 0) ? 31'd0 : c2[30:0];
  end
  always_ff @(posedge clk) begin
    p <= 31'(({31'd0, c1p} * {31'd0, c2p}) >> 30);
    omdlon <= 32'(OneQ30 - cdlon);
    cdlat_d <= cdlat;
  end
  logic [31:0] q;
  always_ff @(posedge clk) begin
    q <= 32'(({32'd0, p} * {31'd0, omdlon}) >> 30);
    cdlat_d2 <= cdlat_d;
  end

  // haversine term, saturated
  logic signed [34:0] hs;
  logic [30:0] h;
  assign hs = (35'(OneQ30) - 35'(cdlat_d2) + 35'({3'd0, q})) >>> 1;
  always_ff @(posedge clk) begin
    if (hs < 0) h <= 31'd0;
    else if (hs > 35'(OneQ30)) h <= 31'd1073741824;
    else h <= hs[30:0];
  end

  // square roots of h and 1-h
  logic [30:0] s, c;
  logic [30:0] omh;
  assign omh = 31'd1073741824 - h;
  hav_sqrt u_s (.clk, .radicand({h, 30'd0}), .root(s));
  hav_sqrt u_cr (.clk, .radicand({omh, 30'd0}), .root(c));

  // arcsine through vectoring cordic, one iteration per stage
  cordic_t av [0:CordicSteps];
  assign av[0] = '{x: {3'd0, c}, y: {3'd0, s}, z: 34'sd0};
  for (genvar i = 0; i < CordicSteps; i++) begin : g_as
    always_ff @(posedge clk) begin
      if (av[i].y >= 0) begin
        av[i+1].x <= av[i].x + (av[i].y >>> i);
        av[i+1].y <= av[i].y - (av[i].x >>> i);
        av[i+1].z <= av[i].z + atan_tab(i);
      end else begin
        av[i+1].x <= av[i].x - (av[i].y >>> i);
        av[i+1].y <= av[i].y + (av[i].x >>> i);
        av[i+1].z <= av[i].z - atan_tab(i);
      end
    end
  end

  // clamp angle, convert to radians, scale by twice the radius
  logic [30:0] a;
  logic [62:0] rprod;
  logic [31:0] r;
  logic [55:0] dprod;
  logic [DistW-1:0] dist_m;
  always_ff @(posedge clk) begin
    if (av[CordicSteps].z < 0) a <= 31'd0;
    else if (av[CordicSteps].z > OneQ30) a <= 31'd1073741824;
    else a <= av[CordicSteps].z[30:0];
    rprod <= 63'({32'd0, a} * {31'd0, PiQ30});
    r <= 32'((rprod + 63'd1073741824) >> 31);
    dprod <= 56'({33'd0, radius} * {24'd0, r});
    dist_m <= DistW'(((dprod << 1) + 56'd536870912) >> 30);
  end

  assign done = vpipe[Latency-1];
  assign coord_error = epipe[Latency-1];
  assign distance_m = epipe[Latency-1] ? '0 : dist_m;
endmodule
`default_nettype wire

// ----- rtl/hav_checker.sv -----
// port-level checker for the haversine distance block, bound to the top level
// depends on haversine_distance_macros.svh
`default_nettype none
`include "haversine_distance_macros.svh"
module hav_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic busy,
  input wire logic done,
  input wire logic coord_error,
  input wire logic [24:0] distance_m,
  input wire logic pready
);
  `HD_ASSERT_IMP(a_err_zero, done && coord_error, distance_m == 25'd0, "error beat nonzero")
  `HD_ASSERT_IMP(a_range, done, distance_m <= 25'd26353590, "distance out of range")
  `HD_ASSERT_IMP(a_ready, 1'b1, pready && !busy, "block stalled")
  `HD_ASSERT_NXT(a_rst_quiet, $past(rst), !done || !$past(rst, 2), "beat after reset")
endmodule
bind haversine_distance hav_checker u_hav_checker (.*);
`default_nettype wire
